FILE: hdl/mci_pkg.sv
// shared types, constants and helper functions of the 4x4 adjugate inverse
package mci_pkg;

  localparam int ELEM_W        = 32;
  localparam int MATRIX_DIM    = 4;
  localparam int ELEMS         = MATRIX_DIM * MATRIX_DIM;
  localparam int IDX_W         = $clog2(ELEMS);
  localparam int FRAC_BITS_DEF = 16;
  // exact products and sums: triple products < 2^96, determinant < 2^130
  localparam int WIDE_W        = 136;

  // handshake status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } mci_unit_st_t;

  // column permutation p of a 3x3 minor, packed {col2, col1, col0}
  function automatic logic [5:0] perm3(input logic [2:0] p);
    logic [5:0] r;
    case (p)
      3'd0:    r = {2'd2, 2'd1, 2'd0};
      3'd1:    r = {2'd0, 2'd2, 2'd1};
      3'd2:    r = {2'd1, 2'd0, 2'd2};
      3'd3:    r = {2'd1, 2'd2, 2'd0};
      3'd4:    r = {2'd2, 2'd0, 2'd1};
      3'd5:    r = {2'd0, 2'd1, 2'd2};
      default: r = {2'd2, 2'd1, 2'd0};
    endcase
    return r;
  endfunction

  function automatic logic perm_odd(input logic [2:0] p);
    return (p >= 3'd3);
  endfunction

  // store address of factor i of permutation p in the minor of (row, col)
  function automatic logic [IDX_W-1:0] cof_addr(input logic [1:0] row,
                                                input logic [1:0] col,
                                                input logic [2:0] p,
                                                input logic [1:0] i);
    logic [5:0] pc;
    logic [1:0] ci;
    logic [1:0] rr;
    logic [1:0] cc;
    pc = perm3(p);
    ci = pc[2*i +: 2];
    rr = (i < row) ? i : i + 2'd1;
    cc = (ci < col) ? ci : ci + 2'd1;
    return {rr, cc};
  endfunction

  // clip a magnitude with sign to 32-bit two's complement, returns {clip, value}
  function automatic logic [ELEM_W:0] sat32(input logic hi_nz,
                                            input logic [ELEM_W-1:0] lo,
                                            input logic neg);
    logic clip;
    logic [ELEM_W-1:0] v;
    if (neg) begin
      clip = hi_nz || (lo > {1'b1, {(ELEM_W-1){1'b0}}});
      v    = clip ? {1'b1, {(ELEM_W-1){1'b0}}} : (~lo + 1'b1);
    end else begin
      clip = hi_nz || lo[ELEM_W-1];
      v    = clip ? {1'b0, {(ELEM_W-1){1'b1}}} : lo;
    end
    return {clip, v};
  endfunction

endpackage

FILE: hdl/mci_chan_if.sv
// valid/ready channel interfaces for matrix elements in and inverse elements out
interface mci_in_if import mci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface mci_out_if import mci_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] result_element;
  logic [ELEM_W-1:0] determinant;
  logic              singular;
  logic              saturated;
  logic              last;

  modport source (output valid, output result_element, output determinant,
                  output singular, output saturated, output last, input ready);
  modport sink   (input valid, input result_element, input determinant,
                  input singular, input saturated, input last, output ready);
endinterface

FILE: hdl/matrix4_cofactor_inverse.sv
// top level: 4x4 fixed-point matrix inverse by adjugate and cofactor expansion
// The block loads sixteen signed Q(31-F).F elements in row-major order, one per
// input transfer, then computes the exact determinant by expansion along row 0
// and streams out sixteen inverse elements in row-major order, each rounded to
// nearest (ties away from zero) and clipped to 32 bits, with the rounded and
// clipped determinant, a singular flag, a clip flag and last on the sixteenth.
// A matrix with an exactly zero determinant is passed back unchanged. The input
// is not ready while a matrix is being worked on. Every product runs through one
// shift-add multiplier at one bit per cycle, so a cofactor costs 18 products; the
// determinant takes four cofactors and four more products; each inverse element
// takes one cofactor plus one pass of the bit-serial divider. A singular matrix
// skips the cofactors of the second pass.
module matrix4_cofactor_inverse import mci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mci_in_if.sink     in_ch,
  mci_out_if.source  out_ch
);
  localparam int N_W = WIDE_W + 2 * FRAC_BITS + 2;

  // one-hot sequencer states
  typedef enum logic [10:0] {
    S_LOAD     = 11'b000_0000_0001,
    S_CF_INIT  = 11'b000_0000_0010,
    S_RD       = 11'b000_0000_0100,
    S_MUL_GO   = 11'b000_0000_1000,
    S_MUL_WAIT = 11'b000_0001_0000,
    S_CF_DONE  = 11'b000_0010_0000,
    S_DIV_WAIT = 11'b000_0100_0000,
    S_DET_DONE = 11'b000_1000_0000,
    S_SG_RD    = 11'b001_0000_0000,
    S_SG_LD    = 11'b010_0000_0000,
    S_OUT      = 11'b100_0000_0000
  } mci_state_t;

  mci_state_t state_r, state_nxt;

  // element store, written during load, read with a registered port
  logic [ELEM_W-1:0] mem [ELEMS];
  logic [ELEM_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_addr;

  logic [IDX_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;        // det pass: column j, inverse pass: element
  logic [2:0]        p_r, p_nxt;        // permutation of the minor
  logic [1:0]        i_r, i_nxt;        // factor within the permutation
  logic              phase_r, phase_nxt; // 0 determinant, 1 inverse elements
  logic              dm_r, dm_nxt;      // multiplying a cofactor by its row-0 element

  logic [WIDE_W-1:0] t_mag_r, t_mag_nxt;
  logic              t_neg_r, t_neg_nxt;
  logic [WIDE_W-1:0] sum_r, sum_nxt;
  logic [WIDE_W-1:0] det_r, det_nxt;
  logic [WIDE_W-1:0] dmag_r, dmag_nxt;
  logic [ELEM_W-1:0] det_raw_r, det_raw_nxt;
  logic              det_neg_r, det_neg_nxt;
  logic              sing_r, sing_nxt;
  logic              cf_neg_r, cf_neg_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] out_res_r, out_res_nxt;
  logic              out_sat_r, out_sat_nxt;

  // row and column of the cofactor being built
  logic [1:0]        cf_row, cf_col;
  logic [WIDE_W-1:0] cf, cf_mag, term;
  logic [WIDE_W-1:0] rnd;
  logic [ELEM_W:0]   det_sat, q_sat;

  logic              in_xfer, out_xfer;

  logic              mul_start, div_start;
  logic [WIDE_W-1:0] mul_prod;
  logic [N_W-1:0]    div_num, div_quo;
  logic [WIDE_W-1:0] div_den;
  mci_unit_st_t      mul_st, div_st;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;

  assign cf_row = phase_r ? k_r[1:0] : 2'd0;
  assign cf_col = phase_r ? k_r[3:2] : k_r[1:0];

  always_comb begin
    if (state_r == S_SG_RD) rd_addr = k_r;
    else if (dm_r)          rd_addr = {2'd0, k_r[1:0]};
    else                    rd_addr = cof_addr(cf_row, cf_col, p_r, i_r);
  end

  always_ff @(posedge clk) begin
    if (in_xfer) mem[load_cnt_r] <= in_ch.element;
    rd_data_r <= mem[rd_addr];
  end

  // signed product term and finished cofactor
  assign term   = (t_neg_r ^ perm_odd(p_r)) ? (~mul_prod + 1'b1) : mul_prod;
  assign cf     = (cf_row[0] ^ cf_col[0]) ? (~sum_r + 1'b1) : sum_r;
  assign cf_mag = cf[WIDE_W-1] ? (~cf + 1'b1) : cf;

  assign rnd     = (dmag_nxt + (WIDE_W'(1) << (3 * FRAC_BITS - 1))) >> (3 * FRAC_BITS);
  assign det_sat = sat32(|rnd[WIDE_W-1:ELEM_W], rnd[ELEM_W-1:0], det_r[WIDE_W-1]);
  assign q_sat   = sat32(|div_quo[N_W-1:ELEM_W], div_quo[ELEM_W-1:0],
                         cf_neg_r ^ det_neg_r);

  assign div_num = (N_W'(cf_mag) << (2 * FRAC_BITS + 1)) + N_W'(dmag_r);
  assign div_den = dmag_r << 1;

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    phase_nxt     = phase_r;
    dm_nxt        = dm_r;
    t_mag_nxt     = t_mag_r;
    t_neg_nxt     = t_neg_r;
    sum_nxt       = sum_r;
    det_nxt       = det_r;
    dmag_nxt      = det_r[WIDE_W-1] ? (~det_r + 1'b1) : det_r;
    det_raw_nxt   = det_raw_r;
    det_neg_nxt   = det_neg_r;
    sing_nxt      = sing_r;
    cf_neg_nxt    = cf_neg_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_sat_nxt   = out_sat_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          load_cnt_nxt = load_cnt_r + 1'b1;
          if (load_cnt_r == IDX_W'(ELEMS - 1)) begin
            state_nxt = S_CF_INIT;
            phase_nxt = 1'b0;
            k_nxt     = '0;
            det_nxt   = '0;
            dm_nxt    = 1'b0;
          end
        end
      end
      S_CF_INIT: begin
        sum_nxt   = '0;
        p_nxt     = '0;
        i_nxt     = '0;
        t_mag_nxt = WIDE_W'(1);
        t_neg_nxt = 1'b0;
        state_nxt = S_RD;
      end
      S_RD: state_nxt = S_MUL_GO;
      S_MUL_GO: begin
        mul_start = 1'b1;
        t_neg_nxt = t_neg_r ^ rd_data_r[ELEM_W-1];
        state_nxt = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (mul_st.done) begin
          if (dm_r) begin
            // det accumulates cofactor(0,j) * a[0][j]
            det_nxt = det_r + (t_neg_r ? (~mul_prod + 1'b1) : mul_prod);
            dm_nxt  = 1'b0;
            if (k_r[1:0] == 2'd3) begin
              state_nxt = S_DET_DONE;
            end else begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_CF_INIT;
            end
          end else if (i_r != 2'd2) begin
            t_mag_nxt = mul_prod;
            i_nxt     = i_r + 1'b1;
            state_nxt = S_RD;
          end else begin
            sum_nxt = sum_r + term;
            if (p_r == 3'd5) begin
              state_nxt = S_CF_DONE;
            end else begin
              p_nxt     = p_r + 1'b1;
              i_nxt     = '0;
              t_mag_nxt = WIDE_W'(1);
              t_neg_nxt = 1'b0;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_CF_DONE: begin
        if (!phase_r) begin
          t_mag_nxt = cf_mag;
          t_neg_nxt = cf[WIDE_W-1];
          dm_nxt    = 1'b1;
          state_nxt = S_RD;
        end else begin
          cf_neg_nxt = cf[WIDE_W-1];
          div_start  = 1'b1;
          state_nxt  = S_DIV_WAIT;
        end
      end
      S_DET_DONE: begin
        sing_nxt    = (det_r == '0);
        det_neg_nxt = det_r[WIDE_W-1];
        det_raw_nxt = det_sat[ELEM_W-1:0];
        k_nxt       = '0;
        phase_nxt   = 1'b1;
        state_nxt   = (det_r == '0) ? S_SG_RD : S_CF_INIT;
      end
      S_DIV_WAIT: begin
        if (div_st.done) begin
          out_res_nxt   = q_sat[ELEM_W-1:0];
          out_sat_nxt   = q_sat[ELEM_W];
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_SG_RD: state_nxt = S_SG_LD;
      S_SG_LD: begin
        out_res_nxt   = rd_data_r;
        out_sat_nxt   = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (k_r == IDX_W'(ELEMS - 1)) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = sing_r ? S_SG_RD : S_CF_INIT;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      dm_r        <= 1'b0;
      phase_r     <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      dm_r        <= dm_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    i_r       <= i_nxt;
    t_mag_r   <= t_mag_nxt;
    t_neg_r   <= t_neg_nxt;
    sum_r     <= sum_nxt;
    det_r     <= det_nxt;
    dmag_r    <= dmag_nxt;
    det_raw_r <= det_raw_nxt;
    det_neg_r <= det_neg_nxt;
    sing_r    <= sing_nxt;
    cf_neg_r  <= cf_neg_nxt;
    out_res_r <= out_res_nxt;
    out_sat_r <= out_sat_nxt;
  end

  // shared multiplier: running product times the magnitude of one element
  mci_mul #(
    .A_W (WIDE_W),
    .B_W (ELEM_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (t_mag_r),
    .b     (rd_data_r[ELEM_W-1] ? (~rd_data_r + 1'b1) : rd_data_r),
    .prod  (mul_prod),
    .st    (mul_st)
  );

  // rounded quotient: (|cf| * 2^(2F+1) + |det|) / (2 * |det|)
  mci_div #(
    .N_W (N_W),
    .D_W (WIDE_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .st    (div_st)
  );

  assign in_ch.ready           = (state_r == S_LOAD);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_element = out_res_r;
  assign out_ch.determinant    = det_raw_r;
  assign out_ch.singular       = sing_r;
  assign out_ch.saturated      = out_sat_r;
  assign out_ch.last           = (k_r == IDX_W'(ELEMS - 1));

  ap_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT) else $error("result shown outside output state");
  ap_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && sing_r |-> !out_sat_r) else $error("clip flagged on singular pass");
  ap_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !mul_st.busy && !div_st.busy)
    else $error("arithmetic unit busy while loading");
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_res_r))
    else $error("pending result dropped");
endmodule

FILE: hdl/mci_mul.sv
// shift-add multiplier, one bit of the narrow operand per cycle
module mci_mul import mci_pkg::*; #(
  parameter int A_W = WIDE_W,
  parameter int B_W = ELEM_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [A_W-1:0] a,
  input  logic [B_W-1:0] b,
  output logic [A_W-1:0] prod,
  output mci_unit_st_t   st
);
  localparam int CNT_W = $clog2(B_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B_W - 1);

  logic [A_W-1:0]   a_r, acc_r;
  logic [B_W-1:0]   b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r, done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign prod    = acc_r;
  assign st.busy = run_r;
  assign st.done = done_r;

  ap_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !start) else $error("multiplier restarted while busy");
  ap_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("multiplier done held over two cycles");
  ap_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r) else $error("multiplier done while still running");
endmodule

FILE: hdl/mci_div.sv
// restoring divider, one quotient bit per cycle
module mci_div import mci_pkg::*; #(
  parameter int N_W = WIDE_W + 2 * FRAC_BITS_DEF + 2,
  parameter int D_W = WIDE_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [N_W-1:0] quo,
  output mci_unit_st_t   st
);
  localparam int CNT_W = $clog2(N_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(N_W - 1);

  logic [N_W-1:0]   n_r, q_r;
  logic [D_W-1:0]   d_r, rem_r;
  logic [D_W:0]     trial;
  logic             ge;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r, done_r;

  assign trial = {rem_r, n_r[N_W-1]};
  assign ge    = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      n_r   <= n_r << 1;
      rem_r <= ge ? D_W'(trial - {1'b0, d_r}) : D_W'(trial);
      q_r   <= {q_r[N_W-2:0], ge};
    end
  end

  assign quo     = q_r;
  assign st.busy = run_r;
  assign st.done = done_r;

  ap_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !start) else $error("divider restarted while busy");
  ap_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r && $past(run_r) |-> rem_r < d_r) else $error("divider remainder out of range");
  ap_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held over two cycles");
endmodule

FILE: tb/tb_matrix4_cofactor_inverse.sv
// self-checking testbench for the 4x4 adjugate matrix inverse
module tb_matrix4_cofactor_inverse;
  import mci_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int CYCLE_CAP = 4000000;
  localparam int ONE       = 1 << FB;

  // exact arithmetic: determinant below 2^130, shifted numerator below 2^132
  typedef logic signed [199:0] wide_t;

  typedef struct {
    logic [31:0] res;
    logic [31:0] det;
    logic        sing;
    logic        sat;
    logic        last;
  } inv_elem_t;

  logic clk;
  logic rst_n;

  mci_in_if  in_bus();
  mci_out_if out_bus();

  matrix4_cofactor_inverse #(.FRAC_BITS(FB)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  inv_elem_t   inv_expected[$];
  logic [31:0] loaded[ELEMS];
  int          load_pos;
  int          mismatches;
  int          cycles;
  bit          calm;  // no idling on either side while set

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic wide_t sx(logic [31:0] e);
    return wide_t'($signed(e));
  endfunction

  // signed cofactor of (row, col) at scale 2^(3F)
  function automatic wide_t cofactor_of(logic [31:0] m[ELEMS], int row, int col);
    int    rr[3];
    int    cc[3];
    int    k;
    int    n;
    wide_t a[3][3];
    wide_t d;
    k = 0;
    n = 0;
    for (int i = 0; i < MATRIX_DIM; i++) begin
      if (i != row) begin
        rr[k] = i;
        k++;
      end
      if (i != col) begin
        cc[n] = i;
        n++;
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = sx(m[rr[i] * MATRIX_DIM + cc[j]]);
    d = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
      - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
      + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    return ((row + col) % 2 == 1) ? -d : d;
  endfunction

  // clip a magnitude with sign to 32 bits, returns {clip, value}
  function automatic logic [32:0] clip32(wide_t mag, logic neg);
    if (neg) begin
      if (mag > wide_t'(64'h8000_0000)) return {1'b1, 32'h8000_0000};
      return {1'b0, 32'(-mag)};
    end
    if (mag > wide_t'(64'h7FFF_FFFF)) return {1'b1, 32'h7FFF_FFFF};
    return {1'b0, mag[31:0]};
  endfunction

  // expected sixteen inverse elements of a fully loaded matrix
  task automatic predict_inverse(logic [31:0] m[ELEMS]);
    wide_t       det;
    wide_t       dmag;
    wide_t       cf;
    wide_t       q;
    wide_t       cmag;
    logic [32:0] dsat;
    logic [32:0] rsat;
    logic        sing;
    inv_elem_t   e;
    det = '0;
    for (int j = 0; j < MATRIX_DIM; j++) det += sx(m[j]) * cofactor_of(m, 0, j);
    sing = (det == 0);
    dmag = (det < 0) ? -det : det;
    dsat = clip32((dmag + (wide_t'(1) <<< (3 * FB - 1))) >>> (3 * FB), det < 0);
    for (int k = 0; k < ELEMS; k++) begin
      if (sing) begin
        rsat = {1'b0, m[k]};
      end else begin
        cf   = cofactor_of(m, k % MATRIX_DIM, k / MATRIX_DIM);
        cmag = (cf < 0) ? -cf : cf;
        // rounded to nearest, ties away from zero
        q    = ((cmag <<< (2 * FB + 1)) + dmag) / (dmag <<< 1);
        rsat = clip32(q, (cf < 0) != (det < 0));
      end
      e.res  = rsat[31:0];
      e.sat  = rsat[32];
      e.det  = dsat[31:0];
      e.sing = sing;
      e.last = (k == ELEMS - 1);
      inv_expected.push_back(e);
    end
  endtask

  function automatic int idle_draw();
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  // one element transfer; valid stays high when the next one follows at once
  task automatic send_element(logic [31:0] value);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.element <= value;
    do @(posedge clk); while (!in_bus.ready);
    loaded[load_pos] = value;
    load_pos++;
    if (load_pos == ELEMS) begin
      load_pos = 0;
      predict_inverse(loaded);
    end
  endtask

  task automatic send_matrix(logic [31:0] m[ELEMS]);
    for (int k = 0; k < ELEMS; k++) send_element(m[k]);
  endtask

  function automatic void make_diag(output logic [31:0] m[ELEMS], input logic [31:0] d0,
                                    input logic [31:0] d1, input logic [31:0] d2,
                                    input logic [31:0] d3);
    for (int k = 0; k < ELEMS; k++) m[k] = '0;
    m[0]  = d0;
    m[5]  = d1;
    m[10] = d2;
    m[15] = d3;
  endfunction

  // result side: ready drops for a random number of cycles before each transfer
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = idle_draw();
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    inv_elem_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (inv_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: element %h det %h", out_bus.result_element,
                   out_bus.determinant);
      end else begin
        e = inv_expected.pop_front();
        if (out_bus.result_element !== e.res || out_bus.determinant !== e.det ||
            out_bus.singular !== e.sing || out_bus.saturated !== e.sat ||
            out_bus.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp elem %h det %h sing %b sat %b last %b, got %h %h %b %b %b",
                     e.res, e.det, e.sing, e.sat, e.last, out_bus.result_element,
                     out_bus.determinant, out_bus.singular, out_bus.saturated, out_bus.last);
        end
      end
    end
  end

  // identity, then a diagonal matrix of -1.0, 1.0, -1.0 and 2.0
  task automatic test_identity();
    logic [31:0] m[ELEMS];
    make_diag(m, ONE, ONE, ONE, ONE);
    send_matrix(m);
    make_diag(m, -ONE, ONE, -ONE, 2 * ONE);
    send_matrix(m);
  endtask

  // field extremes in an upper triangular matrix, clipped results
  task automatic test_extremes();
    logic [31:0] m[ELEMS];
    make_diag(m, 32'h7FFF_FFFF, 32'h8000_0000, ONE, -ONE);
    m[1] = 32'h8000_0000;
    m[2] = 32'h7FFF_FFFF;
    m[7] = 32'hFFFF_FFFF;
    send_matrix(m);
  endtask

  // exactly zero determinant: matrix comes back unchanged
  task automatic test_singular();
    logic [31:0] m[ELEMS];
    for (int k = 0; k < ELEMS; k++) m[k] = $urandom();
    for (int c = 0; c < MATRIX_DIM; c++) m[8 + c] = m[c];
    send_matrix(m);
  endtask

  // nonzero determinant that rounds to a zero field
  task automatic test_tiny_det();
    logic [31:0] m[ELEMS];
    make_diag(m, 32'h10, 32'h10, 32'h10, -32'sh10);
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    logic [31:0] m[ELEMS];
    int          kind;
    for (int n = 0; n < count; n++) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 19);
      for (int k = 0; k < ELEMS; k++) begin
        if (kind < 12) begin
          // well conditioned: strong diagonal, off-diagonal within +-0.5
          if (k % 5 == 0)
            m[k] = (($urandom_range(0, 1) != 0) ? -1 : 1) *
                   int'($urandom_range(ONE / 2, 8 * ONE));
          else
            m[k] = 32'(int'($urandom_range(0, ONE)) - ONE / 2);
        end else if (kind < 15) begin
          m[k] = $urandom();
        end else if (kind < 17) begin
          m[k] = 32'(int'($urandom_range(0, 512)) - 256);
        end else begin
          m[k] = 32'(int'($urandom_range(0, 4 * ONE)) - 2 * ONE);
        end
      end
      // singular variants: a copied row or a zero column
      if (kind == 18)
        for (int c = 0; c < MATRIX_DIM; c++)
          m[4 * $urandom_range(1, 3) + c] = m[c];
      if (kind == 19)
        for (int r = 0; r < MATRIX_DIM; r++) m[4 * r + 2] = '0;
      send_matrix(m);
    end
    calm = 1'b0;
  endtask

  initial begin
    int wait_cycles;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.element <= '0;
    mismatches     = 0;
    cycles         = 0;
    load_pos       = 0;
    calm           = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_identity();
    test_extremes();
    test_singular();
    test_tiny_det();
    test_random(27);

    in_bus.valid <= 1'b0;
    wait_cycles = 0;
    while (inv_expected.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0 && inv_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mci_pkg.sv
hdl/mci_chan_if.sv
hdl/mci_mul.sv
hdl/mci_div.sv
hdl/matrix4_cofactor_inverse.sv
tb/tb_matrix4_cofactor_inverse.sv
